/* design/cbta_pkg.sv */
package cbta_pkg;

  localparam int VAL_W   = 16;
  localparam int SUM_W   = 19;
  localparam int CTR_W   = $clog2(SUM_W);
  localparam int CNT_W   = 3;
  localparam int NUM_QTY = 4;
  localparam int ADDR_W  = 3;

  localparam logic [10:0]      ID_BATTERY_FIRST = 11'h518;
  localparam logic [10:0]      ID_SERIAL        = 11'h520;
  localparam logic [10:0]      ID_SHUTDOWN      = 11'h103;
  localparam logic [VAL_W-1:0] RAW_INVALID      = 16'hFFFF;
  localparam logic [CNT_W-1:0] ACTIVE_RESET     = 3'd4;

  localparam logic REG_ACTIVE = 1'b0;

  localparam logic KIND_REPORT   = 1'b0;
  localparam logic KIND_POWEROFF = 1'b1;

  localparam int QTY_CURRENT = 1;

  typedef struct packed {
    logic [VAL_W-1:0] temperature;
    logic [VAL_W-1:0] charge;
    logic [VAL_W-1:0] current;
    logic [VAL_W-1:0] voltage;
  } reading_t;

  typedef struct packed {
    logic load;
    logic sum_en;
    logic div_load;
    logic div_en;
  } lane_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_DLD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

endpackage

/* design/cbta_if.sv */
interface cbta_frame_if;
  logic        valid;
  logic        ready;
  logic [10:0] can_id;
  logic [3:0]  frame_length;
  logic [63:0] payload;

  modport source (output valid, output can_id, output frame_length, output payload,
                  input ready);
  modport sink (input valid, input can_id, input frame_length, input payload,
                output ready);
endinterface

interface cbta_result_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic        [15:0] mean_voltage_mv;
  logic signed [15:0] mean_current_ma;
  logic        [15:0] mean_charge_centi;
  logic        [15:0] mean_temp_decikelvin;
  logic        [3:0]  valid_mask;

  modport source (output valid, output result_kind, output mean_voltage_mv,
                  output mean_current_ma, output mean_charge_centi,
                  output mean_temp_decikelvin, output valid_mask, input ready);
  modport sink (input valid, input result_kind, input mean_voltage_mv,
                input mean_current_ma, input mean_charge_centi,
                input mean_temp_decikelvin, input valid_mask, output ready);
endinterface

/* design/cbta_apb_cfg.sv */
module cbta_apb_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbta_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [cbta_pkg::CNT_W-1:0]  active_o
);
  import cbta_pkg::*;

  logic [CNT_W-1:0] active_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_ACTIVE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
    end else if (wr_en) begin
      active_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ACTIVE) begin
      prdata = {{(32-CNT_W){1'b0}}, active_q};
    end
  end

  assign active_o = active_q;
endmodule

/* design/cbta_slot_store.sv */
module cbta_slot_store #(
  parameter int SLOT_COUNT = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  wr_en_i,
  input  logic [1:0]                            wr_slot_i,
  input  cbta_pkg::reading_t                    wr_data_i,
  input  logic                                  clear_i,
  output cbta_pkg::reading_t [SLOT_COUNT-1:0]   slots_o
);
  import cbta_pkg::*;

  reading_t [SLOT_COUNT-1:0] slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (clear_i) begin
      slot_q <= '0;
    end else begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        if (wr_en_i && (wr_slot_i == 2'(k))) begin
          slot_q[k] <= wr_data_i;
        end
      end
    end
  end

  assign slots_o = slot_q;
endmodule

/* design/cbta_mean_lane.sv */
module cbta_mean_lane #(
  parameter int SLOT_COUNT = 4
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  cbta_pkg::lane_ctrl_t                         ctrl_i,
  input  logic                                         signed_i,
  input  logic [SLOT_COUNT-1:0][cbta_pkg::VAL_W-1:0]   vals_i,
  input  logic [SLOT_COUNT-1:0]                        inc_i,
  output logic [cbta_pkg::VAL_W-1:0]                   mean_o,
  output logic                                         ok_o
);
  import cbta_pkg::*;

  logic [SLOT_COUNT-1:0][VAL_W-1:0] opnd_q, opnd_d;
  logic [SLOT_COUNT-1:0]            inc_q;
  logic                             signed_q;
  logic [1:0]                       carry_q;
  logic [2:0]                       total;
  logic [SUM_W-1:0]                 sum_q, sum_abs;
  logic                             neg_q;
  logic [SUM_W-1:0]                 dvd_q;
  logic [1:0]                       rem_q;
  logic [SUM_W-1:0]                 quo_q;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [2:0]                       rt, rdiff;
  logic                             ge;
  logic [VAL_W-1:0]                 quo_lo, mean;

  always_comb begin
    total = {1'b0, carry_q};
    cnt_d = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      total     = total + {2'b00, opnd_q[k][0] & inc_q[k]};
      opnd_d[k] = {signed_q & opnd_q[k][VAL_W-1], opnd_q[k][VAL_W-1:1]};
      cnt_d     = cnt_d + {{(CNT_W-1){1'b0}}, inc_i[k]};
    end
    sum_abs = (signed_q && sum_q[SUM_W-1]) ? (~sum_q + 1'b1) : sum_q;
    rt      = {rem_q, dvd_q[SUM_W-1]};
    ge      = (rt >= cnt_q);
    rdiff   = rt - cnt_q;
    quo_lo  = quo_q[VAL_W-1:0];
    mean    = neg_q ? (~quo_lo + 1'b1) : quo_lo;
  end

  assign ok_o   = (cnt_q != '0);
  assign mean_o = ok_o ? mean : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
      cnt_q   <= '0;
    end else if (ctrl_i.load) begin
      carry_q <= '0;
      cnt_q   <= cnt_d;
    end else if (ctrl_i.sum_en) begin
      carry_q <= total[2:1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      opnd_q   <= vals_i;
      inc_q    <= inc_i;
      signed_q <= signed_i;
    end else if (ctrl_i.sum_en) begin
      opnd_q <= opnd_d;
      sum_q  <= {total[0], sum_q[SUM_W-1:1]};
    end
    if (ctrl_i.div_load) begin
      neg_q <= signed_q & sum_q[SUM_W-1];
      dvd_q <= sum_abs;
      rem_q <= '0;
      quo_q <= '0;
    end else if (ctrl_i.div_en) begin
      dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
      rem_q <= ge ? rdiff[1:0] : rt[1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
  end
endmodule

/* design/can_battery_telemetry_averager_unit.sv */
// battery frames are registered in the slot store and the next frame is taken at once
// a shutdown frame goes straight to the finish state, where its item is registered once the output can take it
// a serial-number frame runs bit-serial summing, a division load step and
// bit-serial division in the four mean lanes, then goes to the finish state
// no frame is taken while a report or power-off item is being computed
// reset clears the slot store to zero and sets active_batteries to 4
module can_battery_telemetry_averager_unit #(
  parameter int SLOT_COUNT = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  cbta_frame_if.sink                  frame_i,
  cbta_result_if.source               result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbta_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cbta_pkg::*;

  state_e                                  state_q, state_d;
  logic [CTR_W-1:0]                        ctr_q, ctr_d;
  logic [CNT_W-1:0]                        active, n_eff;
  logic                                    accept, is_batt, is_serial, is_shut;
  logic                                    wr_en, commit, kind_q;
  reading_t [SLOT_COUNT-1:0]               slots;
  logic [NUM_QTY-1:0][SLOT_COUNT-1:0][VAL_W-1:0] qvals;
  logic [NUM_QTY-1:0][SLOT_COUNT-1:0]      inc;
  logic [NUM_QTY-1:0][VAL_W-1:0]           means;
  logic [NUM_QTY-1:0]                      oks;
  lane_ctrl_t                              lane_ctrl;
  logic                                    out_valid_q;

  cbta_apb_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .active_o (active)
  );

  assign n_eff = (active > CNT_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT) : active;

  assign frame_i.ready = (state_q == ST_IDLE);
  assign accept    = frame_i.valid & frame_i.ready;
  assign is_batt   = (frame_i.can_id[10:2] == ID_BATTERY_FIRST[10:2]);
  assign is_serial = (frame_i.can_id == ID_SERIAL);
  assign is_shut   = (frame_i.can_id == ID_SHUTDOWN) && (frame_i.frame_length == 4'd1)
                     && (frame_i.payload[7:0] == 8'd0);
  assign wr_en     = accept & is_batt & ({1'b0, frame_i.can_id[1:0]} < n_eff);

  cbta_slot_store #(.SLOT_COUNT(SLOT_COUNT)) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_slot_i (frame_i.can_id[1:0]),
    .wr_data_i (reading_t'(frame_i.payload)),
    .clear_i   (accept & is_serial),
    .slots_o   (slots)
  );

  always_comb begin
    for (int q = 0; q < NUM_QTY; q++) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        qvals[q][k] = slots[k][VAL_W*q +: VAL_W];
        inc[q][k]   = (CNT_W'(k) < n_eff) && (qvals[q][k] != RAW_INVALID);
      end
    end
  end

  assign lane_ctrl.load     = accept & is_serial;
  assign lane_ctrl.sum_en   = (state_q == ST_SUM);
  assign lane_ctrl.div_load = (state_q == ST_DLD);
  assign lane_ctrl.div_en   = (state_q == ST_DIV);

  for (genvar q = 0; q < NUM_QTY; q++) begin : g_lane
    cbta_mean_lane #(.SLOT_COUNT(SLOT_COUNT)) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .signed_i (q == QTY_CURRENT),
      .vals_i   (qvals[q]),
      .inc_i    (inc[q]),
      .mean_o   (means[q]),
      .ok_o     (oks[q])
    );
  end

  assign commit = (state_q == ST_FIN) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d = state_q;
    ctr_d   = ctr_q;
    case (state_q)
      ST_IDLE: begin
        ctr_d = '0;
        if (accept && is_serial) begin
          state_d = ST_SUM;
        end else if (accept && is_shut) begin
          state_d = ST_FIN;
        end
      end
      ST_SUM: begin
        if (ctr_q == CTR_W'(SUM_W - 1)) begin
          ctr_d   = '0;
          state_d = ST_DLD;
        end else begin
          ctr_d = ctr_q + 1'b1;
        end
      end
      ST_DLD: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (ctr_q == CTR_W'(SUM_W - 1)) begin
          ctr_d   = '0;
          state_d = ST_FIN;
        end else begin
          ctr_d = ctr_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        ctr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (is_serial || is_shut)) begin
      kind_q <= is_serial ? KIND_REPORT : KIND_POWEROFF;
    end
    if (commit) begin
      result_o.result_kind <= kind_q;
      if (kind_q == KIND_POWEROFF) begin
        result_o.mean_voltage_mv      <= '0;
        result_o.mean_current_ma      <= '0;
        result_o.mean_charge_centi    <= '0;
        result_o.mean_temp_decikelvin <= '0;
        result_o.valid_mask           <= '0;
      end else begin
        result_o.mean_voltage_mv      <= means[0];
        result_o.mean_current_ma      <= means[1];
        result_o.mean_charge_centi    <= means[2];
        result_o.mean_temp_decikelvin <= means[3];
        result_o.valid_mask           <= oks;
      end
    end
  end

  assign result_o.valid = out_valid_q;

  a_dld_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DLD |=> state_q == ST_DIV)
    else $error("division load not followed by division");

  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q && (state_q == ST_IDLE))
    else $error("result commit did not present item");

  a_poweroff_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_o.result_kind == KIND_POWEROFF) |->
      (result_o.valid_mask == '0) && (result_o.mean_voltage_mv == '0) &&
      (result_o.mean_current_ma == '0) && (result_o.mean_charge_centi == '0) &&
      (result_o.mean_temp_decikelvin == '0))
    else $error("power-off item carries nonzero fields");

  a_invalid_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.valid_mask[1] |-> result_o.mean_current_ma == '0)
    else $error("current mean without valid reading is nonzero");
endmodule

/* test/can_battery_telemetry_averager_unit_tb.sv */
module can_battery_telemetry_averager_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbta_pkg::*;

  localparam int SLOTS = 4;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_OFF_LEN = 400;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef logic [SLOTS-1:0][VAL_W-1:0] lane_t;

  typedef struct packed {
    logic [10:0] id;
    logic [3:0]  len;
    logic [63:0] data;
  } can_frame_t;

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] volt;
    logic [VAL_W-1:0] curr;
    logic [VAL_W-1:0] chg;
    logic [VAL_W-1:0] temp;
    logic [3:0]       mask;
  } telemetry_t;

  typedef struct packed {
    logic       is_cfg;
    logic [2:0] cfg;
    can_frame_t f;
    logic       typed;
    telemetry_t want;
  } step_t;

  localparam telemetry_t NONE = '0;
  localparam telemetry_t ZERO_REPORT = '{KIND_REPORT, 16'd0, 16'd0, 16'd0, 16'd0, 4'hF};
  localparam telemetry_t EMPTY_REPORT = '{KIND_REPORT, 16'd0, 16'd0, 16'd0, 16'd0, 4'h0};
  localparam telemetry_t POWER_OFF = '{KIND_POWEROFF, 16'd0, 16'd0, 16'd0, 16'd0, 4'h0};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cbta_frame_if  frame_bus ();
  cbta_result_if result_bus ();

  can_battery_telemetry_averager_unit #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_bus),
    .result_o(result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  lane_t      store_volt, store_curr, store_chg, store_temp;
  logic [2:0] active_cfg;
  telemetry_t expected_reports[$];
  int         fails = 0;
  bit         no_idle = 1'b0;
  bit         hold_req = 1'b0;

  step_t plan[$] = '{
    // zeros after reset count as valid readings
    '{1'b0, 3'd0, '{ID_SERIAL, 4'd8, 64'h0}, 1'b1, ZERO_REPORT},
    '{1'b0, 3'd0, '{ID_SHUTDOWN, 4'd1, 64'h0}, 1'b1, POWER_OFF},
    '{1'b0, 3'd0, '{ID_SHUTDOWN, 4'd1, 64'hFFFF_FFFF_FFFF_FF00}, 1'b1, POWER_OFF},
    '{1'b0, 3'd0, '{ID_SHUTDOWN, 4'd0, 64'h0}, 1'b0, NONE},
    '{1'b0, 3'd0, '{ID_SHUTDOWN, 4'd1, 64'h1}, 1'b0, NONE},
    '{1'b0, 3'd0, '{ID_SHUTDOWN, 4'd15, 64'h0}, 1'b0, NONE},
    '{1'b0, 3'd0, '{11'h518, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, NONE},
    '{1'b0, 3'd0, '{11'h519, 4'd0, 64'hFFFE_FFFE_8000_FFFE}, 1'b0, NONE},
    '{1'b0, 3'd0, '{11'h51A, 4'd15, 64'h0000_0000_7FFF_0000}, 1'b0, NONE},
    '{1'b0, 3'd0, '{11'h51B, 4'd3, 64'h8001_4E20_FFFF_7FFF}, 1'b0, NONE},
    '{1'b0, 3'd0, '{ID_SERIAL, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, NONE},
    // store was cleared by the report
    '{1'b0, 3'd0, '{ID_SERIAL, 4'd15, 64'h0}, 1'b1, ZERO_REPORT},
    // negative current mean truncates toward zero
    '{1'b0, 3'd0, '{11'h518, 4'd8, 64'h0BB8_1388_FFFD_0001}, 1'b0, NONE},
    '{1'b0, 3'd0, '{11'h519, 4'd8, 64'h0BB9_1389_FFFE_0002}, 1'b0, NONE},
    '{1'b0, 3'd0, '{ID_SERIAL, 4'd8, 64'h0}, 1'b0, NONE},
    // no active slot
    '{1'b1, 3'd0, '0, 1'b0, NONE},
    '{1'b0, 3'd0, '{11'h518, 4'd8, 64'h1111_2222_3333_4444}, 1'b0, NONE},
    '{1'b0, 3'd0, '{ID_SERIAL, 4'd8, 64'h0}, 1'b1, EMPTY_REPORT},
    // above the slot count acts as all slots
    '{1'b1, 3'd7, '0, 1'b0, NONE},
    '{1'b0, 3'd0, '{11'h51B, 4'd8, 64'h1234_5678_9ABC_DEF0}, 1'b0, NONE},
    '{1'b0, 3'd0, '{ID_SERIAL, 4'd8, 64'h0}, 1'b0, NONE},
    // slot beyond active count, then a register change keeps the store
    '{1'b1, 3'd1, '0, 1'b0, NONE},
    '{1'b0, 3'd0, '{11'h519, 4'd8, 64'h0101_0202_0303_0404}, 1'b0, NONE},
    '{1'b0, 3'd0, '{11'h518, 4'd8, 64'h0E10_2710_8000_F000}, 1'b0, NONE},
    '{1'b1, 3'd4, '0, 1'b0, NONE},
    '{1'b0, 3'd0, '{ID_SERIAL, 4'd8, 64'h0}, 1'b0, NONE},
    '{1'b0, 3'd0, '{11'h51C, 4'd8, 64'hFEDC_BA98_7654_3210}, 1'b0, NONE},
    '{1'b0, 3'd0, '{11'h517, 4'd8, 64'h0123_4567_89AB_CDEF}, 1'b0, NONE}
  };

  function automatic logic [VAL_W-1:0] lane_mean(input lane_t vals, input int unsigned n,
                                                 input bit is_signed, output bit ok);
    int total;
    int cnt;
    total = 0;
    cnt = 0;
    for (int k = 0; k < n; k++) begin
      if (vals[k] != RAW_INVALID) begin
        total += is_signed ? int'($signed(vals[k])) : int'(vals[k]);
        cnt++;
      end
    end
    ok = (cnt > 0);
    return ok ? VAL_W'(total / cnt) : '0;
  endfunction

  function automatic void apply_frame(input can_frame_t f, output bit emits,
                                      output telemetry_t r);
    int unsigned n;
    int unsigned s;
    bit okv, oki, okc, okt;
    n = (active_cfg > SLOTS) ? SLOTS : active_cfg;
    emits = 1'b0;
    r = '0;
    if (f.id >= ID_BATTERY_FIRST && f.id < ID_BATTERY_FIRST + 11'd4) begin
      s = f.id - ID_BATTERY_FIRST;
      if (s < n) begin
        store_volt[s] = f.data[15:0];
        store_curr[s] = f.data[31:16];
        store_chg[s]  = f.data[47:32];
        store_temp[s] = f.data[63:48];
      end
    end else if (f.id == ID_SERIAL) begin
      emits = 1'b1;
      r.kind = KIND_REPORT;
      r.volt = lane_mean(store_volt, n, 1'b0, okv);
      r.curr = lane_mean(store_curr, n, 1'b1, oki);
      r.chg  = lane_mean(store_chg, n, 1'b0, okc);
      r.temp = lane_mean(store_temp, n, 1'b0, okt);
      r.mask = {okt, okc, oki, okv};
      store_volt = '0;
      store_curr = '0;
      store_chg  = '0;
      store_temp = '0;
    end else if (f.id == ID_SHUTDOWN && f.len == 4'd1 && f.data[7:0] == 8'h00) begin
      emits = 1'b1;
      r.kind = KIND_POWEROFF;
    end
  endfunction

  function automatic logic [VAL_W-1:0] rand_reading();
    case ($urandom_range(0, 9))
      0: return RAW_INVALID;
      1: return 16'h0000;
      2: return 16'hFFFE;
      3: return 16'h8000;
      4: return 16'h7FFF;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] rand_len();
    return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
  endfunction

  function automatic can_frame_t battery_frame();
    return '{ID_BATTERY_FIRST + 11'($urandom_range(0, 3)), rand_len(),
             {rand_reading(), rand_reading(), rand_reading(), rand_reading()}};
  endfunction

  function automatic can_frame_t closing_frame();
    if ($urandom_range(0, 99) < 85)
      return '{ID_SERIAL, rand_len(), {$urandom, $urandom}};
    return '{ID_SHUTDOWN, 4'd1, {$urandom, 24'($urandom), 8'h00}};
  endfunction

  function automatic can_frame_t stray_frame();
    logic [3:0] l;
    l = 4'($urandom_range(0, 14));
    if (l >= 4'd1) l++;
    case ($urandom_range(0, 7))
      0: return '{11'h517, rand_len(), {$urandom, $urandom}};
      1: return '{11'h51C, rand_len(), {$urandom, $urandom}};
      2: return '{11'h51F, rand_len(), {$urandom, $urandom}};
      3: return '{11'h521, rand_len(), {$urandom, $urandom}};
      4: return '{11'h102 + 11'(2 * $urandom_range(0, 1)), 4'd1, 64'h0};
      5: return '{ID_SHUTDOWN, l, {$urandom, 24'($urandom), 8'h00}};
      6: return '{ID_SHUTDOWN, 4'd1, {$urandom, 24'($urandom), 8'($urandom_range(1, 255))}};
      default: return '{11'($urandom_range(0, 2047)), 4'($urandom_range(0, 15)),
                        {$urandom, $urandom}};
    endcase
  endfunction

  task automatic send_frame(input can_frame_t f, input bit typed, input telemetry_t want);
    bit emits;
    telemetry_t r;
    if (!no_idle && $urandom_range(0, 99) < 13) begin
      frame_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    frame_bus.valid        <= 1'b1;
    frame_bus.can_id       <= f.id;
    frame_bus.frame_length <= f.len;
    frame_bus.payload      <= f.data;
    do @(posedge clk_i); while (!frame_bus.ready);
    apply_frame(f, emits, r);
    if (typed) expected_reports.insert(expected_reports.size(), want);
    else if (emits) expected_reports.insert(expected_reports.size(), r);
  endtask

  task automatic drain();
    frame_bus.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_active(input logic [2:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ACTIVE, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    active_cfg = value;
  endtask

  task automatic run_random(input int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 99) < 78) begin
        repeat ($urandom_range(0, 5)) begin
          send_frame(battery_frame(), 1'b0, NONE);
          sent++;
        end
        send_frame(closing_frame(), 1'b0, NONE);
        sent++;
      end else begin
        send_frame(stray_frame(), 1'b0, NONE);
      end
    end
  endtask

  task automatic check_report();
    telemetry_t want;
    if (expected_reports.size() == 0) begin
      $error("unexpected item: result_kind %0d, valid_mask %h",
             result_bus.result_kind, result_bus.valid_mask);
      fails++;
      return;
    end
    want = expected_reports[0];
    expected_reports.delete(0);
    if (result_bus.result_kind !== want.kind) begin
      $error("result_kind: expected %0d, got %0d", want.kind, result_bus.result_kind);
      fails++;
    end
    if (result_bus.mean_voltage_mv !== want.volt) begin
      $error("mean_voltage_mv: expected %0d, got %0d", want.volt, result_bus.mean_voltage_mv);
      fails++;
    end
    if (result_bus.mean_current_ma !== want.curr) begin
      $error("mean_current_ma: expected %0d, got %0d", $signed(want.curr),
             result_bus.mean_current_ma);
      fails++;
    end
    if (result_bus.mean_charge_centi !== want.chg) begin
      $error("mean_charge_centi: expected %0d, got %0d", want.chg,
             result_bus.mean_charge_centi);
      fails++;
    end
    if (result_bus.mean_temp_decikelvin !== want.temp) begin
      $error("mean_temp_decikelvin: expected %0d, got %0d", want.temp,
             result_bus.mean_temp_decikelvin);
      fails++;
    end
    if (result_bus.valid_mask !== want.mask) begin
      $error("valid_mask: expected %h, got %h", want.mask, result_bus.valid_mask);
      fails++;
    end
  endtask

  // receiver with random stalls and a long hold-off on request
  initial begin
    int hold_left;
    bit seen_req;
    hold_left = 0;
    seen_req = 1'b0;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_bus.valid && result_bus.ready) check_report();
      if (hold_req != seen_req) begin
        seen_req = hold_req;
        hold_left = HOLD_OFF_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= rst_ni && (no_idle || $urandom_range(0, 99) >= 13);
      end
    end
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("can_battery_telemetry_averager_unit test failed");
    $finish;
  end

  initial begin
    static logic [2:0] phase_setting [8] = '{3'd2, 3'd3, 3'd4, 3'd1, 3'd5, 3'd0, 3'd7, 3'd4};
    rst_ni                 = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    frame_bus.valid        = 1'b0;
    frame_bus.can_id       = '0;
    frame_bus.frame_length = '0;
    frame_bus.payload      = '0;
    store_volt             = '0;
    store_curr             = '0;
    store_chg              = '0;
    store_temp             = '0;
    active_cfg             = ACTIVE_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_active(plan[k].cfg);
      else send_frame(plan[k].f, plan[k].typed, plan[k].want);
    end

    foreach (phase_setting[p]) begin
      write_active(phase_setting[p]);
      no_idle = (p == 2);
      if (p == 3) begin
        // results back up while the receiver holds off
        hold_req = ~hold_req;
        repeat (8) begin
          send_frame(battery_frame(), 1'b0, NONE);
          send_frame(closing_frame(), 1'b0, NONE);
        end
      end
      run_random(ITEMS_PER_PHASE);
    end
    no_idle = 1'b0;

    drain();
    if (fails == 0)
      $display("can_battery_telemetry_averager_unit test passed");
    else
      $display("can_battery_telemetry_averager_unit test failed");
    $finish;
  end

endmodule
